// ===== src/clp_pkg.sv =====
// Shared constants and types for the line segment rectangle clipper.
package clp_pkg;

    // Default coordinate width.
    localparam int COORD_WIDTH_DEF = 16;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Reset values of the clip rectangle.
    localparam int RECT_LEFT_RESET   = 0;
    localparam int RECT_TOP_RESET    = 0;
    localparam int RECT_RIGHT_RESET  = 639;
    localparam int RECT_BOTTOM_RESET = 479;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_BOTTOM = 2'd3
    } reg_idx_t;

    // Axis, side and endpoint codes of one clip sub-step.
    localparam bit AXIS_X   = 1'b0;
    localparam bit AXIS_Y   = 1'b1;
    localparam bit SIDE_MIN = 1'b0;
    localparam bit SIDE_MAX = 1'b1;
    localparam bit PT_START = 1'b0;
    localparam bit PT_END   = 1'b1;

    // Control flags that travel with a word between clip sub-steps.
    typedef struct packed {
        logic vld;
        logic ok;
    } seg_ctl_t;

endpackage

// ===== src/clp_cfg.sv =====
// Configuration register file for the clip rectangle, on an APB-style port.
module clp_cfg #(
    parameter int W = clp_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [clp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [clp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic signed [W-1:0]             rect_left,
    output logic signed [W-1:0]             rect_top,
    output logic signed [W-1:0]             rect_right,
    output logic signed [W-1:0]             rect_bottom
);
    import clp_pkg::*;

    localparam logic [W-1:0] LEFT_RST   = W'(RECT_LEFT_RESET);
    localparam logic [W-1:0] TOP_RST    = W'(RECT_TOP_RESET);
    localparam logic [W-1:0] RIGHT_RST  = W'(RECT_RIGHT_RESET);
    localparam logic [W-1:0] BOTTOM_RST = W'(RECT_BOTTOM_RESET);

    logic signed [W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic signed [W-1:0] rd_val;
    reg_idx_t            idx;
    logic                wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes complete in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= LEFT_RST;
            top_reg    <= TOP_RST;
            right_reg  <= RIGHT_RST;
            bottom_reg <= BOTTOM_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LEFT:   left_reg   <= pwdata[W-1:0];
                REG_TOP:    top_reg    <= pwdata[W-1:0];
                REG_RIGHT:  right_reg  <= pwdata[W-1:0];
                REG_BOTTOM: bottom_reg <= pwdata[W-1:0];
                default:    left_reg   <= left_reg;
            endcase
        end
    end

    // Read data is the register value, sign extended.
    always_comb
    begin
        unique case (idx)
            REG_LEFT:   rd_val = left_reg;
            REG_TOP:    rd_val = top_reg;
            REG_RIGHT:  rd_val = right_reg;
            REG_BOTTOM: rd_val = bottom_reg;
            default:    rd_val = left_reg;
        endcase
    end

    assign prdata      = APB_DATA_W'(rd_val);
    assign rect_left   = left_reg;
    assign rect_top    = top_reg;
    assign rect_right  = right_reg;
    assign rect_bottom = bottom_reg;

endmodule

// ===== src/clp_front.sv =====
// Front end: accepts segment words and holds them in a short queue for the back end.
module clp_front #(
    parameter int W = clp_pkg::COORD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [W-1:0] start_x,
    input  logic signed [W-1:0] start_y,
    input  logic signed [W-1:0] end_x,
    input  logic signed [W-1:0] end_y,
    input  logic                pop,
    output logic                avail,
    output logic signed [W-1:0] q_ax,
    output logic signed [W-1:0] q_ay,
    output logic signed [W-1:0] q_bx,
    output logic signed [W-1:0] q_by
);
    import clp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [4*W-1:0] mem_reg [0:QUEUE_DEPTH-1];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    cnt_reg, cnt_next;
    logic           push, do_pop;
    logic [4*W-1:0] head;

    assign in_stall = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign avail    = (cnt_reg != '0);
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && avail;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= {start_x, start_y, end_x, end_y};
        end
    end

    assign head = mem_reg[rd_ptr_reg];
    assign q_ax = head[4*W-1:3*W];
    assign q_ay = head[3*W-1:2*W];
    assign q_bx = head[2*W-1:W];
    assign q_by = head[W-1:0];

endmodule

// ===== src/clp_step.sv =====
// One clip sub-step: reject test, edge crossing by multiply and pipelined long division.
module clp_step #(
    parameter int W     = clp_pkg::COORD_WIDTH_DEF,
    parameter bit AXIS  = clp_pkg::AXIS_X,
    parameter bit SIDE  = clp_pkg::SIDE_MIN,
    parameter bit WHICH = clp_pkg::PT_START
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  clp_pkg::seg_ctl_t   in_ctl,
    input  logic signed [W-1:0] in_ax,
    input  logic signed [W-1:0] in_ay,
    input  logic signed [W-1:0] in_bx,
    input  logic signed [W-1:0] in_by,
    input  logic signed [W-1:0] rect_left,
    input  logic signed [W-1:0] rect_top,
    input  logic signed [W-1:0] rect_right,
    input  logic signed [W-1:0] rect_bottom,
    output clp_pkg::seg_ctl_t   out_ctl,
    output logic signed [W-1:0] out_ax,
    output logic signed [W-1:0] out_ay,
    output logic signed [W-1:0] out_bx,
    output logic signed [W-1:0] out_by
);
    import clp_pkg::*;

    // Magnitude of a (W+1)-bit signed difference; it always fits W bits.
    function automatic logic [W-1:0] mag(input logic signed [W:0] v);
        logic [W:0] n;
        n = -v;
        return v[W] ? n[W-1:0] : v[W-1:0];
    endfunction

    // Check stage signals.
    logic signed [W-1:0] p_a, p_o, q_a, q_o, edge_v;
    logic signed [W:0]   tn, td, dv;
    logic                rej, beyond;

    // Check stage registers.
    logic                s0_vld_reg, s0_ok_reg, s0_bey_reg, s0_neg_reg;
    logic signed [W-1:0] s0_ax_reg, s0_ay_reg, s0_bx_reg, s0_by_reg;
    logic [W-1:0]        s0_dv_reg, s0_tn_reg, s0_td_reg;
    logic [2*W-1:0]      prod;

    // Product stage (index 0) and division stages (1..W).
    logic                vld_reg [0:W];
    logic                ok_reg  [0:W];
    logic                bey_reg [0:W];
    logic                neg_reg [0:W];
    logic signed [W-1:0] ax_reg  [0:W];
    logic signed [W-1:0] ay_reg  [0:W];
    logic signed [W-1:0] bx_reg  [0:W];
    logic signed [W-1:0] by_reg  [0:W];
    logic [W-1:0]        d_reg   [0:W];
    logic [W-1:0]        rem_reg [0:W];
    logic [W-1:0]        lo_reg  [0:W];
    logic [W-1:0]        q_reg   [0:W];

    // Fix stage signals and registers.
    logic signed [W-1:0] f_po;
    logic signed [W+1:0] base;
    logic signed [W-1:0] new_o;
    logic                fx_vld_reg, fx_ok_reg;
    logic signed [W-1:0] fx_ax_reg, fx_ay_reg, fx_bx_reg, fx_by_reg;

    // Select the endpoint under test, the other endpoint and the edge.
    always_comb
    begin
        p_a    = (WHICH == PT_END) ? ((AXIS == AXIS_Y) ? in_by : in_bx)
                                   : ((AXIS == AXIS_Y) ? in_ay : in_ax);
        p_o    = (WHICH == PT_END) ? ((AXIS == AXIS_Y) ? in_bx : in_by)
                                   : ((AXIS == AXIS_Y) ? in_ax : in_ay);
        q_a    = (WHICH == PT_END) ? ((AXIS == AXIS_Y) ? in_ay : in_ax)
                                   : ((AXIS == AXIS_Y) ? in_by : in_bx);
        q_o    = (WHICH == PT_END) ? ((AXIS == AXIS_Y) ? in_ax : in_ay)
                                   : ((AXIS == AXIS_Y) ? in_bx : in_by);
        edge_v = (AXIS == AXIS_Y) ? ((SIDE == SIDE_MAX) ? rect_bottom : rect_top)
                                  : ((SIDE == SIDE_MAX) ? rect_right : rect_left);
        rej    = (in_ax < rect_left  && in_bx < rect_left)  ||
                 (in_ax > rect_right && in_bx > rect_right) ||
                 (in_ay < rect_top   && in_by < rect_top)   ||
                 (in_ay > rect_bottom && in_by > rect_bottom);
        beyond = (SIDE == SIDE_MAX) ? (p_a > edge_v) : (p_a < edge_v);
        tn     = (W+1)'(p_a) - (W+1)'(edge_v);
        td     = (W+1)'(p_a) - (W+1)'(q_a);
        dv     = (W+1)'(q_o) - (W+1)'(p_o);
    end

    assign prod = (2*W)'(s0_dv_reg) * (2*W)'(s0_tn_reg);

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            fx_vld_reg <= 1'b0;
            for (int j = 0; j <= W; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            s0_vld_reg <= in_ctl.vld;
            vld_reg[0] <= s0_vld_reg;
            for (int j = 0; j < W; j++)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
            fx_vld_reg <= vld_reg[W];
        end
    end

    // Payload of the check, product and division stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ok_reg  <= in_ctl.ok && !rej && !(beyond && td == '0);
            s0_bey_reg <= beyond;
            s0_neg_reg <= dv[W] ^ tn[W] ^ td[W];
            s0_ax_reg  <= in_ax;
            s0_ay_reg  <= in_ay;
            s0_bx_reg  <= in_bx;
            s0_by_reg  <= in_by;
            s0_dv_reg  <= mag(dv);
            s0_tn_reg  <= mag(tn);
            s0_td_reg  <= mag(td);

            ok_reg[0]  <= s0_ok_reg;
            bey_reg[0] <= s0_bey_reg;
            neg_reg[0] <= s0_neg_reg;
            ax_reg[0]  <= s0_ax_reg;
            ay_reg[0]  <= s0_ay_reg;
            bx_reg[0]  <= s0_bx_reg;
            by_reg[0]  <= s0_by_reg;
            d_reg[0]   <= s0_td_reg;
            rem_reg[0] <= prod[2*W-1:W];
            lo_reg[0]  <= prod[W-1:0];
            q_reg[0]   <= '0;

            // One quotient bit per stage, restoring division.
            for (int j = 0; j < W; j++)
            begin
                ok_reg[j+1]  <= ok_reg[j];
                bey_reg[j+1] <= bey_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ax_reg[j+1]  <= ax_reg[j];
                ay_reg[j+1]  <= ay_reg[j];
                bx_reg[j+1]  <= bx_reg[j];
                by_reg[j+1]  <= by_reg[j];
                d_reg[j+1]   <= d_reg[j];
                lo_reg[j+1]  <= {lo_reg[j][W-2:0], 1'b0};
                if ({rem_reg[j], lo_reg[j][W-1]} >= {1'b0, d_reg[j]})
                begin
                    rem_reg[j+1] <= W'({rem_reg[j], lo_reg[j][W-1]} - {1'b0, d_reg[j]});
                    q_reg[j+1]   <= {q_reg[j][W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j+1] <= W'({rem_reg[j], lo_reg[j][W-1]});
                    q_reg[j+1]   <= {q_reg[j][W-2:0], 1'b0};
                end
            end
        end
    end

    // New coordinate on the other axis, truncated toward zero.
    always_comb
    begin
        f_po = (WHICH == PT_END) ? ((AXIS == AXIS_Y) ? bx_reg[W] : by_reg[W])
                                 : ((AXIS == AXIS_Y) ? ax_reg[W] : ay_reg[W]);
        if (neg_reg[W])
        begin
            base = (W+2)'(f_po) - (W+2)'($signed({1'b0, q_reg[W]}))
                   - (W+2)'($signed({1'b0, rem_reg[W] != '0}));
        end
        else
        begin
            base = (W+2)'(f_po) + (W+2)'($signed({1'b0, q_reg[W]}));
        end
        if (rem_reg[W] != '0 && base < 0)
        begin
            base = base + (W+2)'(1);
        end
        new_o = base[W-1:0];
    end

    // Fix stage: move the endpoint onto the edge when it lies beyond it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_ok_reg <= ok_reg[W];
            fx_ax_reg <= ax_reg[W];
            fx_ay_reg <= ay_reg[W];
            fx_bx_reg <= bx_reg[W];
            fx_by_reg <= by_reg[W];
            if (ok_reg[W] && bey_reg[W])
            begin
                if (WHICH == PT_END)
                begin
                    fx_bx_reg <= (AXIS == AXIS_Y) ? new_o : edge_v;
                    fx_by_reg <= (AXIS == AXIS_Y) ? edge_v : new_o;
                end
                else
                begin
                    fx_ax_reg <= (AXIS == AXIS_Y) ? new_o : edge_v;
                    fx_ay_reg <= (AXIS == AXIS_Y) ? edge_v : new_o;
                end
            end
        end
    end

    assign out_ctl.vld = fx_vld_reg;
    assign out_ctl.ok  = fx_ok_reg;
    assign out_ax      = fx_ax_reg;
    assign out_ay      = fx_ay_reg;
    assign out_bx      = fx_bx_reg;
    assign out_by      = fx_by_reg;

endmodule

// ===== src/line_segment_rect_clipper.sv =====
// Top level of the line segment rectangle clipper.
// Throughput: one segment per cycle while the output is not stalled; each of the eight sub-steps is a pipeline of
// COORD_WIDTH + 3 stages set by its one-bit-per-stage long division.
// A four-word input queue absorbs input while the output is stalled.
// Reset (rst_n, asynchronous, active low) empties the queue and the pipeline and
// loads the rectangle 0, 0, 639, 479; it needs no clearing pass.
module line_segment_rect_clipper #(
    parameter int COORD_WIDTH = clp_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [clp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [clp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [COORD_WIDTH-1:0]   start_x,
    input  logic signed [COORD_WIDTH-1:0]   start_y,
    input  logic signed [COORD_WIDTH-1:0]   end_x,
    input  logic signed [COORD_WIDTH-1:0]   end_y,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    output logic signed [COORD_WIDTH-1:0]   clipped_start_x,
    output logic signed [COORD_WIDTH-1:0]   clipped_start_y,
    output logic signed [COORD_WIDTH-1:0]   clipped_end_x,
    output logic signed [COORD_WIDTH-1:0]   clipped_end_y
);
    import clp_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] rect_left, rect_top, rect_right, rect_bottom;
    logic                avail, pipe_adv;
    seg_ctl_t            ch_ctl [0:8];
    logic signed [W-1:0] ch_ax  [0:8];
    logic signed [W-1:0] ch_ay  [0:8];
    logic signed [W-1:0] ch_bx  [0:8];
    logic signed [W-1:0] ch_by  [0:8];

    logic                out_vld_reg, acc_reg;
    logic signed [W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    clp_cfg #(.W(W)) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom)
    );

    // The back pipeline moves whenever the output register can take a word.
    assign pipe_adv = !(out_vld_reg && out_stall);

    clp_front #(.W(W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .pop      (pipe_adv),
        .avail    (avail),
        .q_ax     (ch_ax[0]),
        .q_ay     (ch_ay[0]),
        .q_bx     (ch_bx[0]),
        .q_by     (ch_by[0])
    );

    assign ch_ctl[0].vld = avail;
    assign ch_ctl[0].ok  = 1'b1;

    // Eight sub-steps in order: x min, x max, y min, y max; start point then end point.
    for (genvar k = 0; k < 8; k++)
    begin : g_step
        clp_step #(
            .W     (W),
            .AXIS  (1'(k >> 2)),
            .SIDE  (1'(k >> 1)),
            .WHICH (1'(k))
        ) u_step (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (pipe_adv),
            .in_ctl      (ch_ctl[k]),
            .in_ax       (ch_ax[k]),
            .in_ay       (ch_ay[k]),
            .in_bx       (ch_bx[k]),
            .in_by       (ch_by[k]),
            .rect_left   (rect_left),
            .rect_top    (rect_top),
            .rect_right  (rect_right),
            .rect_bottom (rect_bottom),
            .out_ctl     (ch_ctl[k+1]),
            .out_ax      (ch_ax[k+1]),
            .out_ay      (ch_ay[k+1]),
            .out_bx      (ch_bx[k+1]),
            .out_by      (ch_by[k+1])
        );
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            out_vld_reg <= ch_ctl[8].vld;
        end
    end

    // Rejected segments report zero coordinates.
    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            acc_reg <= ch_ctl[8].ok;
            sx_reg  <= ch_ctl[8].ok ? ch_ax[8] : '0;
            sy_reg  <= ch_ctl[8].ok ? ch_ay[8] : '0;
            ex_reg  <= ch_ctl[8].ok ? ch_bx[8] : '0;
            ey_reg  <= ch_ctl[8].ok ? ch_by[8] : '0;
        end
    end

    assign out_valid       = out_vld_reg;
    assign accepted        = acc_reg;
    assign clipped_start_x = sx_reg;
    assign clipped_start_y = sy_reg;
    assign clipped_end_x   = ex_reg;
    assign clipped_end_y   = ey_reg;

endmodule

// ===== src/clp_checker.sv =====
// Port-level checker for the clipper and its bind to the top level.
module clp_checker #(
    parameter int COORD_WIDTH = clp_pkg::COORD_WIDTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [clp_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [clp_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [clp_pkg::APB_DATA_W-1:0]  prdata,
    input logic                            pready,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic signed [COORD_WIDTH-1:0]   start_x,
    input logic signed [COORD_WIDTH-1:0]   start_y,
    input logic signed [COORD_WIDTH-1:0]   end_x,
    input logic signed [COORD_WIDTH-1:0]   end_y,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            accepted,
    input logic signed [COORD_WIDTH-1:0]   clipped_start_x,
    input logic signed [COORD_WIDTH-1:0]   clipped_start_y,
    input logic signed [COORD_WIDTH-1:0]   clipped_end_x,
    input logic signed [COORD_WIDTH-1:0]   clipped_end_y
);

    // A stalled result word stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(accepted) && $stable(clipped_start_x) &&
            $stable(clipped_start_y) && $stable(clipped_end_x) && $stable(clipped_end_y))
        else $error("result word changed while stalled");

    // A rejected segment reports zero coordinates.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> clipped_start_x == '0 && clipped_start_y == '0 &&
            clipped_end_x == '0 && clipped_end_y == '0)
        else $error("rejected segment with nonzero coordinates");

    // No result appears straight out of reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result word valid at reset release");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("configuration access not ready");

endmodule

bind line_segment_rect_clipper clp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_clp_checker (.*);
